// ===== sv/isotp_pkg.sv =====
package isotp_pkg;

  localparam logic [2:0] FLD_MONTH = 3'd0;
  localparam logic [2:0] FLD_DAY   = 3'd1;
  localparam logic [2:0] FLD_HOUR  = 3'd2;
  localparam logic [2:0] FLD_MIN   = 3'd3;
  localparam logic [2:0] FLD_SEC   = 3'd4;
  localparam logic [2:0] FLD_ZH    = 3'd5;
  localparam logic [2:0] FLD_ZM    = 3'd6;

  localparam logic [2:0] STEP_NONE = 3'd0;
  localparam logic [2:0] STEP_1    = 3'd1;
  localparam logic [2:0] STEP_2    = 3'd2;
  localparam logic [2:0] STEP_3    = 3'd3;
  localparam logic [2:0] STEP_4    = 3'd4;
  localparam logic [2:0] STEP_5    = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam logic [23:0] LEAPS_1969P = 24'd478;
  localparam logic [48:0] MS_PER_DAY  = 49'd86400000;

  typedef struct packed {
    logic       year_en;
    logic       first_en;
    logic       pair_en;
    logic [2:0] fld;
    logic [1:0] dc;
    logic       frac_en;
    logic       set_neg;
    logic       zone_clr;
    logic       clear;
    logic [2:0] step;
    logic       out_load;
    logic       ok;
  } cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic year_ge;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2: month_len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] mi);
    case (mi)
      4'd0: month_start = 9'd0;
      4'd1: month_start = 9'd31;
      4'd2: month_start = 9'd59;
      4'd3: month_start = 9'd90;
      4'd4: month_start = 9'd120;
      4'd5: month_start = 9'd151;
      4'd6: month_start = 9'd181;
      4'd7: month_start = 9'd212;
      4'd8: month_start = 9'd243;
      4'd9: month_start = 9'd273;
      4'd10: month_start = 9'd304;
      4'd11: month_start = 9'd334;
      default: month_start = 9'd0;
    endcase
  endfunction

endpackage

// ===== sv/isotp_ctrl.sv =====
module isotp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_char_code,
  input  logic                in_last_char,
  input  logic                out_stall,
  input  isotp_pkg::status_t  st,
  output logic                in_stall,
  output logic                out_valid,
  output isotp_pkg::cmd_t     cmd
);

  localparam logic [4:0] PH_YEAR            = 5'd0;
  localparam logic [4:0] PH_AFTER_YEAR      = 5'd1;
  localparam logic [4:0] PH_MONTH           = 5'd2;
  localparam logic [4:0] PH_AFTER_MONTH     = 5'd3;
  localparam logic [4:0] PH_DAY             = 5'd4;
  localparam logic [4:0] PH_AFTER_DAY       = 5'd5;
  localparam logic [4:0] PH_HOUR            = 5'd6;
  localparam logic [4:0] PH_AFTER_HOUR      = 5'd7;
  localparam logic [4:0] PH_MINUTE          = 5'd8;
  localparam logic [4:0] PH_AFTER_MINUTE    = 5'd9;
  localparam logic [4:0] PH_SECOND          = 5'd10;
  localparam logic [4:0] PH_AFTER_SECOND    = 5'd11;
  localparam logic [4:0] PH_FRAC_FIRST      = 5'd12;
  localparam logic [4:0] PH_FRAC            = 5'd13;
  localparam logic [4:0] PH_ZONE_HOUR       = 5'd14;
  localparam logic [4:0] PH_AFTER_ZONE_HOUR = 5'd15;
  localparam logic [4:0] PH_ZONE_MIN        = 5'd16;
  localparam logic [4:0] PH_END             = 5'd17;
  localparam logic [4:0] PH_ERROR           = 5'd18;

  logic [4:0] phase_r, phase_nxt;
  logic [1:0] dc_r, dc_nxt;
  logic       dash_r, dash_nxt;
  logic       colon_r, colon_nxt;
  logic [2:0] seq_r, seq_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic acc, dig, zs, fire, accepting;
  logic [4:0] pair_next;

  assign acc       = in_valid && (seq_r == isotp_pkg::STEP_NONE);
  assign in_stall  = (seq_r != isotp_pkg::STEP_NONE);
  assign out_valid = out_valid_r;
  assign dig = (in_char_code >= isotp_pkg::CH_ZERO) && (in_char_code <= isotp_pkg::CH_NINE);
  assign zs  = (in_char_code == isotp_pkg::CH_Z) || (in_char_code == isotp_pkg::CH_PLUS) ||
               (in_char_code == isotp_pkg::CH_DASH);
  assign fire = (seq_r == isotp_pkg::STEP_5) && (!out_valid_r || !out_stall);

  always_comb begin
    case (phase_r)
      PH_AFTER_YEAR, PH_AFTER_DAY, PH_AFTER_HOUR, PH_AFTER_MINUTE, PH_AFTER_SECOND,
      PH_FRAC, PH_AFTER_ZONE_HOUR, PH_END: accepting = 1'b1;
      PH_AFTER_MONTH: accepting = dash_r;
      default: accepting = 1'b0;
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_MONTH:     pair_next = PH_AFTER_MONTH;
      PH_DAY:       pair_next = PH_AFTER_DAY;
      PH_HOUR:      pair_next = PH_AFTER_HOUR;
      PH_MINUTE:    pair_next = PH_AFTER_MINUTE;
      PH_SECOND:    pair_next = PH_AFTER_SECOND;
      PH_ZONE_HOUR: pair_next = PH_AFTER_ZONE_HOUR;
      PH_ZONE_MIN:  pair_next = PH_END;
      default:      pair_next = PH_ERROR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.dc        = dc_r;
    cmd.ok        = accepting && st.year_ge;
    cmd.out_load  = fire;
    cmd.clear     = fire;
    cmd.step      = (seq_r == isotp_pkg::STEP_5) ? isotp_pkg::STEP_NONE : seq_r;
    case (phase_r)
      PH_AFTER_MONTH, PH_DAY: cmd.fld = isotp_pkg::FLD_DAY;
      PH_HOUR: cmd.fld = isotp_pkg::FLD_HOUR;
      PH_AFTER_HOUR, PH_MINUTE: cmd.fld = isotp_pkg::FLD_MIN;
      PH_AFTER_MINUTE, PH_SECOND: cmd.fld = isotp_pkg::FLD_SEC;
      PH_ZONE_HOUR: cmd.fld = isotp_pkg::FLD_ZH;
      PH_AFTER_ZONE_HOUR, PH_ZONE_MIN: cmd.fld = isotp_pkg::FLD_ZM;
      default: cmd.fld = isotp_pkg::FLD_MONTH;
    endcase
    phase_nxt = phase_r;
    dc_nxt    = dc_r;
    dash_nxt  = dash_r;
    colon_nxt = colon_r;
    if (acc && phase_r != PH_ERROR) begin
      phase_nxt = PH_ERROR;
      case (phase_r)
        PH_YEAR: begin
          if (dig) begin
            cmd.year_en = 1'b1;
            dc_nxt = dc_r + 2'd1;
            phase_nxt = (dc_r == 2'd3) ? PH_AFTER_YEAR : PH_YEAR;
          end
        end
        PH_AFTER_YEAR: begin
          if (in_char_code == isotp_pkg::CH_DASH) begin
            dash_nxt = 1'b1; dc_nxt = 2'd0; phase_nxt = PH_MONTH;
          end else if (dig) begin
            cmd.first_en = 1'b1; dc_nxt = 2'd1; phase_nxt = PH_MONTH;
          end else if (in_char_code == isotp_pkg::CH_T) begin
            dc_nxt = 2'd0; phase_nxt = PH_HOUR;
          end
        end
        PH_AFTER_MONTH: begin
          if (dash_r) begin
            if (in_char_code == isotp_pkg::CH_DASH) begin
              dc_nxt = 2'd0; phase_nxt = PH_DAY;
            end else if (in_char_code == isotp_pkg::CH_T) begin
              dc_nxt = 2'd0; phase_nxt = PH_HOUR;
            end
          end else if (dig) begin
            cmd.first_en = 1'b1; dc_nxt = 2'd1; phase_nxt = PH_DAY;
          end
        end
        PH_AFTER_DAY: begin
          if (in_char_code == isotp_pkg::CH_T) begin
            dc_nxt = 2'd0; phase_nxt = PH_HOUR;
          end
        end
        PH_AFTER_HOUR, PH_AFTER_MINUTE, PH_AFTER_SECOND, PH_FRAC: begin
          if (zs) begin
            if (in_char_code == isotp_pkg::CH_Z) begin
              cmd.zone_clr = 1'b1; phase_nxt = PH_END;
            end else begin
              cmd.set_neg = (in_char_code == isotp_pkg::CH_DASH);
              dc_nxt = 2'd0; phase_nxt = PH_ZONE_HOUR;
            end
          end else if (phase_r == PH_AFTER_HOUR) begin
            if (in_char_code == isotp_pkg::CH_COLON) begin
              colon_nxt = 1'b1; dc_nxt = 2'd0; phase_nxt = PH_MINUTE;
            end else if (dig) begin
              cmd.first_en = 1'b1; dc_nxt = 2'd1; phase_nxt = PH_MINUTE;
            end
          end else if (phase_r == PH_AFTER_MINUTE) begin
            if (colon_r) begin
              if (in_char_code == isotp_pkg::CH_COLON) begin
                dc_nxt = 2'd0; phase_nxt = PH_SECOND;
              end
            end else if (dig) begin
              cmd.first_en = 1'b1; dc_nxt = 2'd1; phase_nxt = PH_SECOND;
            end
          end else if (phase_r == PH_AFTER_SECOND) begin
            if (in_char_code == isotp_pkg::CH_DOT || in_char_code == isotp_pkg::CH_COMMA)
              phase_nxt = PH_FRAC_FIRST;
          end else if (dig) begin
            cmd.frac_en = 1'b1; phase_nxt = PH_FRAC;
          end
        end
        PH_FRAC_FIRST: begin
          if (dig) begin
            cmd.frac_en = 1'b1; phase_nxt = PH_FRAC;
          end
        end
        PH_AFTER_ZONE_HOUR: begin
          if (in_char_code == isotp_pkg::CH_COLON) begin
            dc_nxt = 2'd0; phase_nxt = PH_ZONE_MIN;
          end else if (dig) begin
            cmd.first_en = 1'b1; dc_nxt = 2'd1; phase_nxt = PH_ZONE_MIN;
          end
        end
        PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND, PH_ZONE_HOUR, PH_ZONE_MIN: begin
          if (dig) begin
            if (dc_r == 2'd0) begin
              cmd.first_en = 1'b1; dc_nxt = 2'd1; phase_nxt = phase_r;
            end else begin
              dc_nxt = 2'd0;
              if (st.pair_ok) begin
                cmd.pair_en = 1'b1; phase_nxt = pair_next;
              end
            end
          end
        end
        default: phase_nxt = PH_ERROR;
      endcase
    end
    if (fire) begin
      phase_nxt = PH_YEAR; dc_nxt = 2'd0; dash_nxt = 1'b0; colon_nxt = 1'b0;
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      isotp_pkg::STEP_NONE: if (acc && in_last_char) seq_nxt = isotp_pkg::STEP_1;
      isotp_pkg::STEP_5: if (fire) seq_nxt = isotp_pkg::STEP_NONE;
      default: seq_nxt = seq_r + 3'd1;
    endcase
    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_YEAR;
      dc_r        <= 2'd0;
      dash_r      <= 1'b0;
      colon_r     <= 1'b0;
      seq_r       <= isotp_pkg::STEP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      dc_r        <= dc_nxt;
      dash_r      <= dash_nxt;
      colon_r     <= colon_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/isotp_dp.sv =====
module isotp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_char_code,
  input  isotp_pkg::cmd_t     cmd,
  output isotp_pkg::status_t  st,
  output logic signed [48:0]  out_epoch_millis,
  output logic                out_valid_res
);

  logic [13:0] year_r, year_nxt;
  logic [3:0]  yd_r [4];
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [9:0]  frac_r, frac_nxt;
  logic [1:0]  fw_r, fw_nxt;
  logic [3:0]  zh_r, zh_nxt;
  logic [5:0]  zm_r, zm_nxt;
  logic        neg_r, neg_nxt;
  logic        leap_r, leap_nxt;

  logic [26:0]        prod_a_r;
  logic [24:0]        prod_b_r;
  logic [21:0]        base_r;
  logic signed [18:0] tod_r;
  logic signed [23:0] days1_r, days_r;
  logic signed [28:0] todms_r;
  logic [48:0]        mshi_r;
  logic [48:0]        epoch_r;
  logic               vres_r;

  logic [3:0]  d, acc_sel, mi;
  logic [6:0]  v;
  logic        is_leap, r_zero;
  logic [3:0]  lo_mod, hi_mod;
  logic [9:0]  frac_add;
  logic [13:0] n;
  logic [16:0] hms;
  logic [15:0] off;
  logic [18:0] hms_x, off_x;

  assign d = 4'(in_char_code - isotp_pkg::CH_ZERO);

  assign r_zero  = (yd_r[2] == 4'd0) && (yd_r[3] == 4'd0);
  assign lo_mod  = {yd_r[2][0], 1'b0} + yd_r[3];
  assign hi_mod  = {yd_r[0][0], 1'b0} + yd_r[1];
  assign is_leap = r_zero ? (hi_mod[1:0] == 2'd0) : (lo_mod[1:0] == 2'd0);

  always_comb begin
    case (cmd.fld)
      isotp_pkg::FLD_DAY:  acc_sel = day_r[3:0];
      isotp_pkg::FLD_HOUR: acc_sel = hour_r[3:0];
      isotp_pkg::FLD_MIN:  acc_sel = min_r[3:0];
      isotp_pkg::FLD_SEC:  acc_sel = sec_r[3:0];
      isotp_pkg::FLD_ZH:   acc_sel = zh_r;
      isotp_pkg::FLD_ZM:   acc_sel = zm_r[3:0];
      default:             acc_sel = month_r;
    endcase
    v = 7'(acc_sel) * 7'd10 + 7'(d);
    case (cmd.fld)
      isotp_pkg::FLD_DAY: st.pair_ok = (v >= 7'd1) &&
        ((v <= 7'(isotp_pkg::month_len(month_r))) ||
         ((v == 7'd29) && (month_r == 4'd2) && is_leap));
      isotp_pkg::FLD_HOUR: st.pair_ok = (v <= 7'd23);
      isotp_pkg::FLD_MIN:  st.pair_ok = (v <= 7'd59);
      isotp_pkg::FLD_SEC:  st.pair_ok = (v <= 7'd60);
      isotp_pkg::FLD_ZH:   st.pair_ok = (v <= 7'd14);
      isotp_pkg::FLD_ZM:   st.pair_ok = (v <= 7'd59);
      default:             st.pair_ok = (v >= 7'd1) && (v <= 7'd12);
    endcase
    st.year_ge = (year_r >= isotp_pkg::EPOCH_YEAR);
  end

  always_comb begin
    case (fw_r)
      2'd0: frac_add = 10'(d) * 10'd100;
      2'd1: frac_add = 10'(d) * 10'd10;
      2'd2: frac_add = 10'(d);
      default: frac_add = 10'd0;
    endcase
  end

  always_comb begin
    year_nxt = year_r; month_nxt = month_r; day_nxt = day_r; hour_nxt = hour_r;
    min_nxt = min_r; sec_nxt = sec_r; frac_nxt = frac_r; fw_nxt = fw_r;
    zh_nxt = zh_r; zm_nxt = zm_r; neg_nxt = neg_r; leap_nxt = leap_r;
    if (cmd.year_en) year_nxt = 14'(year_r * 14'd10 + 14'(d));
    if (cmd.first_en || cmd.pair_en) begin
      case (cmd.fld)
        isotp_pkg::FLD_DAY:  day_nxt = cmd.pair_en ? v[4:0] : 5'(d);
        isotp_pkg::FLD_HOUR: hour_nxt = cmd.pair_en ? v[4:0] : 5'(d);
        isotp_pkg::FLD_MIN:  min_nxt = cmd.pair_en ? v[5:0] : 6'(d);
        isotp_pkg::FLD_SEC: begin
          if (cmd.pair_en && v == 7'd60) begin
            sec_nxt = 6'd59; frac_nxt = 10'd999; leap_nxt = 1'b1;
          end else begin
            sec_nxt = cmd.pair_en ? v[5:0] : 6'(d);
          end
        end
        isotp_pkg::FLD_ZH:   zh_nxt = cmd.pair_en ? v[3:0] : d;
        isotp_pkg::FLD_ZM:   zm_nxt = cmd.pair_en ? v[5:0] : 6'(d);
        default:             month_nxt = cmd.pair_en ? v[3:0] : d;
      endcase
    end
    if (cmd.frac_en) begin
      if (!leap_r) frac_nxt = frac_r + frac_add;
      if (fw_r != 2'd3) fw_nxt = fw_r + 2'd1;
    end
    if (cmd.set_neg) neg_nxt = 1'b1;
    if (cmd.zone_clr) begin
      zh_nxt = 4'd0; zm_nxt = 6'd0;
    end
    if (cmd.clear) begin
      year_nxt = 14'd0; month_nxt = 4'd1; day_nxt = 5'd1; hour_nxt = 5'd0;
      min_nxt = 6'd0; sec_nxt = 6'd0; frac_nxt = 10'd0; fw_nxt = 2'd0;
      zh_nxt = 4'd0; zm_nxt = 6'd0; neg_nxt = 1'b0; leap_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r <= 14'd0; month_r <= 4'd1; day_r <= 5'd1; hour_r <= 5'd0;
      min_r <= 6'd0; sec_r <= 6'd0; frac_r <= 10'd0; fw_r <= 2'd0;
      zh_r <= 4'd0; zm_r <= 6'd0; neg_r <= 1'b0; leap_r <= 1'b0;
    end else begin
      year_r <= year_nxt; month_r <= month_nxt; day_r <= day_nxt; hour_r <= hour_nxt;
      min_r <= min_nxt; sec_r <= sec_nxt; frac_r <= frac_nxt; fw_r <= fw_nxt;
      zh_r <= zh_nxt; zm_r <= zm_nxt; neg_r <= neg_nxt; leap_r <= leap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) yd_r[i] <= 4'd0;
    end else if (cmd.clear) begin
      for (int i = 0; i < 4; i++) yd_r[i] <= 4'd0;
    end else if (cmd.year_en) begin
      yd_r[cmd.dc] <= d;
    end
  end

  assign n     = year_r - 14'd1;
  assign mi    = (month_r >= 4'd1 && month_r <= 4'd12) ? month_r - 4'd1 : 4'd0;
  assign hms   = 17'(hour_r) * 17'd3600 + 17'(min_r) * 17'd60 + 17'(sec_r);
  assign off   = 16'(10'(zh_r) * 10'd60 + 10'(zm_r)) * 16'd60;
  assign hms_x = 19'(hms);
  assign off_x = 19'(off);

  always_ff @(posedge clk) begin
    case (cmd.step)
      isotp_pkg::STEP_1: begin
        prod_a_r <= 27'(n) * 27'(isotp_pkg::RECIP_100);
        base_r   <= 22'(year_r - isotp_pkg::EPOCH_YEAR) * 22'd365;
        tod_r    <= $signed(neg_r ? hms_x + off_x : hms_x - off_x);
      end
      isotp_pkg::STEP_2: begin
        prod_b_r <= 25'(n[13:2]) * 25'(isotp_pkg::RECIP_100);
        days1_r  <= $signed({2'b00, base_r}) + $signed({12'd0, n[13:2]})
                  - $signed({16'd0, prod_a_r[26:19]})
                  + $signed({15'd0, isotp_pkg::month_start(mi)})
                  + $signed({23'd0, (mi >= 4'd2) && is_leap})
                  + $signed({19'd0, day_r}) - $signed(isotp_pkg::LEAPS_1969P);
      end
      isotp_pkg::STEP_3: begin
        days_r  <= days1_r + $signed({18'd0, prod_b_r[24:19]});
        todms_r <= 29'(tod_r) * 29'sd1000;
      end
      isotp_pkg::STEP_4: begin
        mshi_r <= 49'(days_r[21:0]) * isotp_pkg::MS_PER_DAY;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      epoch_r <= cmd.ok ? mshi_r + 49'(todms_r) + 49'(frac_r) : 49'd0;
      vres_r  <= cmd.ok;
    end
  end

  assign out_epoch_millis = $signed(epoch_r);
  assign out_valid_res    = vres_r;

endmodule

// ===== sv/iso8601_timestamp_parser.sv =====
// channel  ports                                     direction
// input    in_valid in_stall in_char_code in_last_char  in
// result   out_valid out_stall out_epoch_millis out_valid_res  out
//
// One character is taken per cycle while a timestamp streams in.
// After the last character the conversion sequencer steps from STEP_1 to STEP_5
// with in_stall high; the result then loads into the output register when free.
// Reset (rst_n low, synchronous) clears the parser and drops out_valid.
// A held result under out_stall does not block parsing of the next text.
module iso8601_timestamp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [48:0] out_epoch_millis,
  output logic               out_valid_res
);

  isotp_pkg::cmd_t    cmd;
  isotp_pkg::status_t st;

  isotp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .out_stall    (out_stall),
    .st           (st),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  isotp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char_code     (in_char_code),
    .cmd              (cmd),
    .st               (st),
    .out_epoch_millis (out_epoch_millis),
    .out_valid_res    (out_valid_res)
  );

endmodule

// ===== test/isotp_checker.sv =====
module isotp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [48:0] out_epoch_millis,
  input  logic               out_valid_res,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    P_YEAR, P_AFT_YEAR, P_MONTH, P_AFT_MONTH, P_DAY, P_AFT_DAY, P_HOUR,
    P_AFT_HOUR, P_MINUTE, P_AFT_MINUTE, P_SECOND, P_AFT_SECOND, P_FRAC_FIRST,
    P_FRAC, P_ZHOUR, P_AFT_ZHOUR, P_ZMIN, P_END, P_ERR
  } phase_e;

  typedef struct packed {
    logic signed [48:0] millis;
    logic               ok;
  } stamp_t;

  phase_e phase;
  int unsigned dcnt, yr, mon, dy, hr, mn, sc, frac, fw, zh, zm;
  bit dashes, colons, neg, leap;
  stamp_t stamp_q[$];

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(int unsigned m);
    case (m)
      2: return 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic longint leaps_to(longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  task automatic clear_state();
    phase = P_YEAR;
    dcnt = 0; yr = 0; mon = 1; dy = 1; hr = 0; mn = 0; sc = 0;
    frac = 0; fw = 100; zh = 0; zm = 0;
    dashes = 0; colons = 0; neg = 0; leap = 0;
  endtask

  // two-digit collector; returns -1 after the first digit
  function automatic int take_pair(ref int unsigned acc, input int unsigned d);
    if (dcnt == 0) begin
      acc = d;
      dcnt = 1;
      return -1;
    end
    dcnt = 0;
    return acc * 10 + d;
  endfunction

  function automatic bit zone_start(logic [7:0] c);
    if (c == isotp_pkg::CH_Z) begin
      zh = 0; zm = 0; phase = P_END;
      return 1;
    end
    if (c == isotp_pkg::CH_PLUS || c == isotp_pkg::CH_DASH) begin
      if (c == isotp_pkg::CH_DASH) neg = 1;
      dcnt = 0; phase = P_ZHOUR;
      return 1;
    end
    return 0;
  endfunction

  task automatic eat_char(logic [7:0] c);
    bit dg;
    int unsigned d;
    phase_e ph;
    int v;
    dg = c >= isotp_pkg::CH_ZERO && c <= isotp_pkg::CH_NINE;
    d = dg ? c - isotp_pkg::CH_ZERO : 0;
    ph = phase;
    if (ph == P_ERR) return;
    phase = P_ERR;
    case (ph)
      P_YEAR: if (dg) begin
        yr = yr * 10 + d;
        if (dcnt == 3) begin dcnt = 0; phase = P_AFT_YEAR; end
        else begin dcnt++; phase = P_YEAR; end
      end
      P_AFT_YEAR: begin
        if (c == isotp_pkg::CH_DASH) begin dashes = 1; dcnt = 0; phase = P_MONTH; end
        else if (dg) begin mon = d; dcnt = 1; phase = P_MONTH; end
        else if (c == isotp_pkg::CH_T) begin dcnt = 0; phase = P_HOUR; end
      end
      P_MONTH: if (dg) begin
        v = take_pair(mon, d);
        if (v < 0) phase = P_MONTH;
        else if (v >= 1 && v <= 12) begin mon = v; phase = P_AFT_MONTH; end
      end
      P_AFT_MONTH: begin
        if (dashes) begin
          if (c == isotp_pkg::CH_DASH) begin dcnt = 0; phase = P_DAY; end
          else if (c == isotp_pkg::CH_T) begin dcnt = 0; phase = P_HOUR; end
        end else if (dg) begin
          dy = d; dcnt = 1; phase = P_DAY;
        end
      end
      P_DAY: if (dg) begin
        v = take_pair(dy, d);
        if (v < 0) phase = P_DAY;
        else if (v >= 1 && (v <= days_in(mon) || (v == 29 && mon == 2 && is_leap(yr))))
        begin
          dy = v; phase = P_AFT_DAY;
        end
      end
      P_AFT_DAY: if (c == isotp_pkg::CH_T) begin dcnt = 0; phase = P_HOUR; end
      P_HOUR: if (dg) begin
        v = take_pair(hr, d);
        if (v < 0) phase = P_HOUR;
        else if (v <= 23) begin hr = v; phase = P_AFT_HOUR; end
      end
      P_AFT_HOUR: if (!zone_start(c)) begin
        if (c == isotp_pkg::CH_COLON) begin colons = 1; dcnt = 0; phase = P_MINUTE; end
        else if (dg) begin mn = d; dcnt = 1; phase = P_MINUTE; end
      end
      P_MINUTE: if (dg) begin
        v = take_pair(mn, d);
        if (v < 0) phase = P_MINUTE;
        else if (v <= 59) begin mn = v; phase = P_AFT_MINUTE; end
      end
      P_AFT_MINUTE: if (!zone_start(c)) begin
        if (colons) begin
          if (c == isotp_pkg::CH_COLON) begin dcnt = 0; phase = P_SECOND; end
        end else if (dg) begin
          sc = d; dcnt = 1; phase = P_SECOND;
        end
      end
      P_SECOND: if (dg) begin
        v = take_pair(sc, d);
        if (v < 0) phase = P_SECOND;
        else if (v == 60) begin sc = 59; frac = 999; leap = 1; phase = P_AFT_SECOND; end
        else if (v < 60) begin sc = v; phase = P_AFT_SECOND; end
      end
      P_AFT_SECOND: if (!zone_start(c)) begin
        if (c == isotp_pkg::CH_DOT || c == isotp_pkg::CH_COMMA) phase = P_FRAC_FIRST;
      end
      P_FRAC_FIRST, P_FRAC: begin
        if (dg) begin
          if (!leap) frac += d * fw;
          fw /= 10;
          phase = P_FRAC;
        end else if (ph == P_FRAC) begin
          void'(zone_start(c));
        end
      end
      P_ZHOUR: if (dg) begin
        v = take_pair(zh, d);
        if (v < 0) phase = P_ZHOUR;
        else if (v <= 14) begin zh = v; phase = P_AFT_ZHOUR; end
      end
      P_AFT_ZHOUR: begin
        if (c == isotp_pkg::CH_COLON) begin dcnt = 0; phase = P_ZMIN; end
        else if (dg) begin zm = d; dcnt = 1; phase = P_ZMIN; end
      end
      P_ZMIN: if (dg) begin
        v = take_pair(zm, d);
        if (v < 0) phase = P_ZMIN;
        else if (v <= 59) begin zm = v; phase = P_END; end
      end
      default: ;
    endcase
  endtask

  function automatic stamp_t finish_stamp();
    stamp_t r;
    bit done;
    longint y, days, secs, off;
    int unsigned mi;
    r = '0;
    case (phase)
      P_AFT_YEAR, P_AFT_DAY, P_AFT_HOUR, P_AFT_MINUTE, P_AFT_SECOND, P_FRAC,
      P_AFT_ZHOUR, P_END: done = 1;
      P_AFT_MONTH: done = dashes;
      default: done = 0;
    endcase
    if (done && yr >= 1970) begin
      y = yr;
      mi = (mon >= 1 && mon <= 12) ? mon - 1 : 0;
      days = 365 * (y - 1970) + leaps_to(y - 1) - leaps_to(1969);
      days += isotp_pkg::month_start(4'(mi));
      if (mi >= 2 && is_leap(yr)) days += 1;
      days += longint'(dy) - 1;
      secs = days * 86400 + hr * 3600 + mn * 60 + sc;
      off = (longint'(zh) * 60 + zm) * 60;
      if (neg) off = -off;
      secs -= off;
      r.millis = 49'(secs * 1000 + frac);
      r.ok = 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stamp_t exp_s;
    if (!rst_n) begin
      clear_state();
      stamp_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        eat_char(in_char_code);
        if (in_last_char) begin
          stamp_q.push_back(finish_stamp());
          clear_state();
        end
      end
      if (out_valid && !out_stall) begin
        if (stamp_q.size() == 0) begin
          $display("%0t: unexpected transfer millis=%0d ok=%0b", $time,
                   out_epoch_millis, out_valid_res);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = stamp_q.pop_front();
          if (out_epoch_millis !== exp_s.millis || out_valid_res !== exp_s.ok) begin
            $display("%0t: mismatch expected millis=%0d ok=%0b actual millis=%0d ok=%0b",
                     $time, exp_s.millis, exp_s.ok, out_epoch_millis, out_valid_res);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= stamp_q.size();
  end
endmodule

// ===== test/tb_iso8601_timestamp_parser.sv =====
module tb_iso8601_timestamp_parser;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [7:0]         in_char_code = '0;
  logic               in_last_char = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [48:0] out_epoch_millis;
  logic               out_valid_res;
  int                 fail_count, pending_count;
  int                 char_total = 0;
  bit                 quiet = 0;
  bit                 hold_long = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  iso8601_timestamp_parser u_dut (.*);

  isotp_checker u_chk (.*);

  // entered and left at a falling edge
  task automatic send_char(logic [7:0] c, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_char_code <= c;
    in_last_char <= lst;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    char_total++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string two(int v);
    return $sformatf("%02d", v);
  endfunction

  function automatic string rand_stamp();
    string s, sep, ts;
    int y, m, d, f;
    bit dsh, col;
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(1965, 2400);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, 31);
    if ($urandom_range(0, 3) == 0) begin m = 2; d = $urandom_range(28, 29); end
    dsh = 1'($urandom_range(0, 1));
    col = 1'($urandom_range(0, 1));
    s = $sformatf("%04d", y);
    case ($urandom_range(0, 5))
      0: return s;
      1: if (dsh) return {s, "-", two(m)};
      default: ;
    endcase
    s = {s, dsh ? "-" : "", two(m), dsh ? "-" : "", two(d)};
    if ($urandom_range(0, 5) == 0) return s;
    sep = col ? ":" : "";
    s = {s, "T", two($urandom_range(0, 24))};
    f = $urandom_range(0, 3);
    if (f > 0) s = {s, sep, two($urandom_range(0, 60))};
    if (f > 1) s = {s, sep, two($urandom_range(0, 61))};
    if (f > 2) begin
      s = {s, $urandom_range(0, 1) ? "." : ","};
      repeat ($urandom_range(1, 5))
        s = {s, string'(8'(isotp_pkg::CH_ZERO + $urandom_range(0, 9)))};
    end
    case ($urandom_range(0, 3))
      0: ;
      1: s = {s, "Z"};
      default: begin
        ts = $urandom_range(0, 1) ? "+" : "-";
        s = {s, ts, two($urandom_range(0, 15))};
        case ($urandom_range(0, 2))
          0: ;
          1: s = {s, ":", two($urandom_range(0, 60))};
          default: s = {s, two($urandom_range(0, 59))};
        endcase
      end
    endcase
    return s;
  endfunction

  // receiver side: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (60) @(negedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    string s;
    int k;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_text("1970");
    send_text("1970-01-01T00:00:00+14:00");
    send_text("9999-12-31T23:59:60.5-14:00");
    send_text("2000-02-29");
    send_text("1900-02-29");
    send_text("1969-12-31T23:59:59Z");
    send_text("20240229T235959,1234Z");
    hold_long = 1;
    send_text("2016-12-31T23:59:60Z");
    send_text("2001-02");
    send_text("200102");
    send_text("2001T12");
    send_text("2023-06-15T10:30+0530");
    send_text("2023-06-15T10:30:00x");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h7F, 1'b1);
    while (char_total < 520) begin
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) send_char(8'($urandom_range(0, 255)), i == k - 1);
      end else begin
        s = rand_stamp();
        if ($urandom_range(0, 19) == 0)
          s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
        send_text(s);
      end
    end
    quiet = 1;
    while (char_total < 650) send_text(rand_stamp());
    in_valid <= 0;
    k = 0;
    while (pending_count != 0 && k < 10000) begin
      @(negedge clk);
      k++;
    end
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== iso8601_timestamp_parser.f =====
sv/isotp_pkg.sv
sv/isotp_ctrl.sv
sv/isotp_dp.sv
sv/iso8601_timestamp_parser.sv
test/isotp_checker.sv
test/tb_iso8601_timestamp_parser.sv
